@@ hw/rtl/compare_timer_with_count_modes_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the compare timer checker
// Clocked assertion shorthands for the checker file.
// ---------------------------------------------------------------------------
`ifndef COMPARE_TIMER_WITH_COUNT_MODES_UNIT_MACROS_SVH
`define COMPARE_TIMER_WITH_COUNT_MODES_UNIT_MACROS_SVH

// Checked on every edge outside reset.
`define CMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CMT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/cmtmr_pkg.sv @@
// ---------------------------------------------------------------------------
// cmtmr_pkg
// Shared types, register map and codes of the compare timer.
// ---------------------------------------------------------------------------
package cmtmr_pkg;

  localparam int DEFAULT_COUNT_WIDTH = 16;
  localparam int PADDR_WIDTH         = 5;
  localparam int REG_INDEX_WIDTH     = 3;

  // register index = paddr[4:2]
  localparam logic [REG_INDEX_WIDTH-1:0] REG_CLOCK_SOURCE     = 3'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_DIVIDER_EXPONENT = 3'd1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_COUNT_MODE       = 3'd2;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_COMPARE_VALUE    = 3'd3;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_IRQ_ENABLE       = 3'd4;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_OUTPUT_MODE      = 3'd5;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_DIRECT_OUT_BIT   = 3'd6;

  localparam logic [1:0] SRC_MAIN = 2'd0;
  localparam logic [1:0] SRC_SUB  = 2'd2;

  localparam logic [1:0] MODE_STOP   = 2'd0;
  localparam logic [1:0] MODE_UP     = 2'd1;
  localparam logic [1:0] MODE_CONT   = 2'd2;
  localparam logic [1:0] MODE_UPDOWN = 2'd3;

  localparam logic [2:0] OUT_DIRECT = 3'd0;
  localparam logic [2:0] OUT_SET    = 3'd1;
  localparam logic [2:0] OUT_RESET  = 3'd5;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic [1:0]  clock_source;
    logic [1:0]  divider_exponent;
    logic [1:0]  count_mode;
    logic [15:0] compare_value;
    logic        irq_enable;
    logic [2:0]  output_mode;
    logic        direct_out_bit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] count_value;
    logic        match_flag;
    logic        irq_request;
    logic        pin_level;
  } result_t;

endpackage

@@ hw/rtl/cmtmr_regs.sv @@
// ---------------------------------------------------------------------------
// cmtmr_regs
// APB-style configuration registers of the compare timer.
// ---------------------------------------------------------------------------
module cmtmr_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cmtmr_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output cmtmr_pkg::cfg_t                  cfg
);
  import cmtmr_pkg::*;

  logic [REG_INDEX_WIDTH-1:0] index;
  logic                       wr_en;

  assign index  = paddr[PADDR_WIDTH-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (index)
        REG_CLOCK_SOURCE:     cfg.clock_source     <= pwdata[1:0];
        REG_DIVIDER_EXPONENT: cfg.divider_exponent <= pwdata[1:0];
        REG_COUNT_MODE:       cfg.count_mode       <= pwdata[1:0];
        REG_COMPARE_VALUE:    cfg.compare_value    <= pwdata[15:0];
        REG_IRQ_ENABLE:       cfg.irq_enable       <= pwdata[0];
        REG_OUTPUT_MODE:      cfg.output_mode      <= pwdata[2:0];
        REG_DIRECT_OUT_BIT:   cfg.direct_out_bit   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_CLOCK_SOURCE:     prdata = 32'(cfg.clock_source);
      REG_DIVIDER_EXPONENT: prdata = 32'(cfg.divider_exponent);
      REG_COUNT_MODE:       prdata = 32'(cfg.count_mode);
      REG_COMPARE_VALUE:    prdata = 32'(cfg.compare_value);
      REG_IRQ_ENABLE:       prdata = 32'(cfg.irq_enable);
      REG_OUTPUT_MODE:      prdata = 32'(cfg.output_mode);
      REG_DIRECT_OUT_BIT:   prdata = 32'(cfg.direct_out_bit);
      default:              prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/cmtmr_step.sv @@
// ---------------------------------------------------------------------------
// cmtmr_step
// Next-state logic of the timer for one transaction: clock select,
// prescaler, count modes, compare match and output pin action.
// ---------------------------------------------------------------------------
module cmtmr_step #(
  parameter int COUNT_WIDTH = cmtmr_pkg::DEFAULT_COUNT_WIDTH
) (
  input  cmtmr_pkg::cfg_t         cfg,
  input  logic                    op,
  input  logic                    clock_is_main,
  input  logic [COUNT_WIDTH-1:0]  counter,
  input  logic                    counting_up,
  input  logic [2:0]              prescale_count,
  input  logic                    flag_store,
  input  logic                    pin_store,
  output logic [COUNT_WIDTH-1:0]  counter_next,
  output logic                    counting_up_next,
  output logic [2:0]              prescale_count_next,
  output logic                    flag_store_next,
  output logic                    pin_store_next
);
  import cmtmr_pkg::*;

  logic [COUNT_WIDTH-1:0] cmp;
  logic [COUNT_WIDTH-1:0] stepped;
  logic [2:0]             last;
  logic                   selected;
  logic                   advance;
  logic                   match;

  assign cmp  = COUNT_WIDTH'(cfg.compare_value);
  assign last = ~(3'b111 << cfg.divider_exponent);

  assign selected = (op == OP_TICK) && (cfg.count_mode != MODE_STOP) &&
                    ((clock_is_main && cfg.clock_source == SRC_MAIN) ||
                     (!clock_is_main && cfg.clock_source == SRC_SUB));
  // >= covers a count left above the limit by a divider change
  assign advance  = selected && (prescale_count >= last);

  always_comb begin
    if (!selected)     prescale_count_next = prescale_count;
    else if (advance)  prescale_count_next = 3'd0;
    else               prescale_count_next = prescale_count + 3'd1;
  end

  assign stepped = counting_up ? counter + 1'b1 : counter - 1'b1;

  always_comb begin
    counter_next     = counter;
    counting_up_next = counting_up;
    if (advance) begin
      case (cfg.count_mode)
        MODE_UP:   counter_next = (counter >= cmp) ? '0 : counter + 1'b1;
        MODE_CONT: counter_next = counter + 1'b1;  // wraps at all ones
        MODE_UPDOWN: begin
          counter_next = stepped;
          if (stepped >= cmp || stepped == '0) counting_up_next = ~counting_up;
        end
        default: ;
      endcase
    end
  end

  assign match = advance && (counter_next == cmp);

  always_comb begin
    if (op == OP_CLEAR) flag_store_next = 1'b0;
    else                flag_store_next = flag_store | match;
  end

  always_comb begin
    pin_store_next = pin_store;
    if (match) begin
      case (cfg.output_mode)
        OUT_DIRECT: ;
        OUT_SET:    pin_store_next = 1'b1;
        OUT_RESET:  pin_store_next = 1'b0;
        default:    pin_store_next = ~pin_store;
      endcase
    end
    if (cfg.output_mode == OUT_DIRECT) pin_store_next = cfg.direct_out_bit;
  end

endmodule

@@ hw/rtl/compare_timer_with_count_modes_unit.sv @@
// ---------------------------------------------------------------------------
// compare_timer_with_count_modes_unit
// Compare timer with clock select, 2^n prescaler and stop, up, continuous
// and up/down count modes, sticky match flag, interrupt and output pin.
// ---------------------------------------------------------------------------
// The timer takes one transaction per clock cycle, tick or flag clear, and
// answers each with one result, which is registered in the result queue.
// The timer state is updated by a single layer of logic at the input
// handshake, so there is no dependency stall; a two-entry result queue lets
// input keep flowing while one result waits on the output side, and input
// ready drops only when both entries are occupied. Configuration goes
// through the APB port (registers at 4*index, pready always high) and must
// be written while the timer is idle.
module compare_timer_with_count_modes_unit #(
  parameter int COUNT_WIDTH = cmtmr_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cmtmr_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic                              clock_is_main,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       count_value,
  output logic                              match_flag,
  output logic                              irq_request,
  output logic                              pin_level
);
  import cmtmr_pkg::*;

  cfg_t cfg;

  logic [COUNT_WIDTH-1:0] counter, counter_next;
  logic                   counting_up, counting_up_next;
  logic [2:0]             prescale_count, prescale_count_next;
  logic                   flag_store, flag_store_next;
  logic                   pin_store, pin_store_next;

  result_t result_new;
  result_t slot0, slot1;
  logic [1:0] fill;
  logic push, pop;

  cmtmr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cmtmr_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step (
    .cfg                 (cfg),
    .op                  (op),
    .clock_is_main       (clock_is_main),
    .counter             (counter),
    .counting_up         (counting_up),
    .prescale_count      (prescale_count),
    .flag_store          (flag_store),
    .pin_store           (pin_store),
    .counter_next        (counter_next),
    .counting_up_next    (counting_up_next),
    .prescale_count_next (prescale_count_next),
    .flag_store_next     (flag_store_next),
    .pin_store_next      (pin_store_next)
  );

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid & in_ready;
  assign pop      = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter        <= '0;
      counting_up    <= 1'b1;
      prescale_count <= '0;
      flag_store     <= 1'b0;
      pin_store      <= 1'b0;
    end else if (push) begin
      counter        <= counter_next;
      counting_up    <= counting_up_next;
      prescale_count <= prescale_count_next;
      flag_store     <= flag_store_next;
      pin_store      <= pin_store_next;
    end
  end

  assign result_new.count_value = 16'(counter_next);
  assign result_new.match_flag  = flag_store_next;
  assign result_new.irq_request = flag_store_next & cfg.irq_enable;
  assign result_new.pin_level   = pin_store_next;

  // result queue: slot0 is the head shown on the output
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (fill == 2'd2) ? slot1 : result_new;
    end else if (push && fill == 2'd0) begin
      slot0 <= result_new;
    end
    if (push && ((fill == 2'd1 && !pop) || fill == 2'd2)) begin
      slot1 <= result_new;
    end
  end

  assign out_valid   = (fill != 2'd0);
  assign count_value = slot0.count_value;
  assign match_flag  = slot0.match_flag;
  assign irq_request = slot0.irq_request;
  assign pin_level   = slot0.pin_level;

endmodule

@@ hw/rtl/cmtmr_checker.sv @@
// ---------------------------------------------------------------------------
// cmtmr_checker
// Port-level checks of the compare timer, bound to the top level.
// ---------------------------------------------------------------------------
`include "compare_timer_with_count_modes_unit_macros.svh"

module cmtmr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] count_value,
  input logic        match_flag,
  input logic        irq_request,
  input logic        pin_level
);

  // a stalled result holds
  `CMT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(count_value) && $stable(match_flag) && $stable(pin_level), "stalled result changed")

  // interrupt request only with the flag up
  `CMT_ASSERT(a_irq_flag, out_valid && irq_request |-> match_flag, "irq without match flag")

  // input stalls only when results are queued
  `CMT_ASSERT(a_stall_cause, !in_ready |-> out_valid, "input stalled with empty queue")

  // an accepted transaction into an empty queue shows next cycle
  `CMT_ASSERT(a_result_shows, in_valid && in_ready && !out_valid |=> out_valid, "result missing")

  // queue empty after reset
  `CMT_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind compare_timer_with_count_modes_unit cmtmr_checker u_checker (.*);
